FILE: sv/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// Beat payloads, register indexes and reset values of the config registers.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int CMD_W       = 1;
  localparam int STAMP_W     = 32;
  localparam int DIST_OUT_W  = 7;
  localparam int DAC_W       = 12;
  localparam int CFG_REG_W   = 16;
  localparam int CFG_INDEX_W = 4;

  // Command codes carried in the item beat
  localparam logic [CMD_W-1:0] CMD_TICK    = 1'b0;
  localparam logic [CMD_W-1:0] CMD_CAPTURE = 1'b1;

  // Config register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_PERIOD = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ECHO_TIMEOUT   = 4'd1;

  localparam logic [CFG_REG_W-1:0] TRIGGER_PERIOD_RST = 16'd60;
  localparam logic [CFG_REG_W-1:0] ECHO_TIMEOUT_RST   = 16'd35;

  localparam int            US_PER_CM = 58;
  localparam logic [DAC_W-1:0] DAC_FULL = 12'hFFF;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [STAMP_W-1:0] capture_time;
  } item_t;

  typedef struct packed {
    logic                  trigger_fire;
    logic [DIST_OUT_W-1:0] distance;
    logic [DAC_W-1:0]      dac_level;
    logic                  reading_valid;
  } result_t;

endpackage

FILE: sv/uer_cdiv.sv
// ----------------------------------------------------------------------------
// uer_cdiv: unsigned divide by a constant
// Multiplies by a rounded-up reciprocal and keeps the high bits; exact for
// every input of IN_W bits.
// ----------------------------------------------------------------------------
module uer_cdiv #(
  parameter int IN_W    = 16,
  parameter int DIVISOR = 58
) (
  input  logic [IN_W-1:0] x,
  output logic [IN_W-1:0] q
);

  localparam int LOG_D = $clog2(DIVISOR);
  localparam int SHIFT = IN_W + LOG_D;
  localparam int RW    = IN_W + 2;
  localparam int PW    = SHIFT + IN_W;
  localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic [PW-1:0] prod;

  assign prod = PW'(x) * PW'(RECIP[RW-1:0]);
  assign q    = prod[SHIFT +: IN_W];

endmodule

FILE: sv/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit: echo-time distance ranger
// An accepted item beat passes the stage-1 register, then the result register.
// Throughput: one item per cycle while result_stall is low; the stage-1 register
//   and the result register each hold one beat, so a stalled result lets one
//   more item in before item_stall rises.
// Reset (rst, synchronous, active high): counter, edge state, ready flag and
//   distance clear to zero; config registers return to 60 ms and 35 ms.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit #(
  parameter int TIME_WIDTH      = 32,
  parameter int MAX_DISTANCE_CM = 100
) (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          item_valid,
  output logic                          item_stall,
  input  uer_pkg::item_t                item,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output uer_pkg::result_t              result,
  // config write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [uer_pkg::CFG_REG_W-1:0]   cfg_data
);

  // Distance register width and the pulse width at which the quotient
  // would pass the maximum distance.
  localparam int DW     = $clog2(MAX_DISTANCE_CM + 1);
  localparam int LIMIT  = uer_pkg::US_PER_CM * (MAX_DISTANCE_CM + 1);
  localparam int WQ     = $clog2(LIMIT);
  localparam int CW     = (TIME_WIDTH > WQ) ? TIME_WIDTH : WQ;
  localparam int XW     = DW + uer_pkg::DAC_W;
  localparam logic [CW-1:0] LIMIT_W  = CW'(LIMIT);
  localparam logic [DW-1:0] MAX_DIST = DW'(MAX_DISTANCE_CM);
  localparam logic [uer_pkg::CFG_REG_W-1:0] ELAPSED_MAX = '1;

  // --------------------------------------------------------------------------
  // Config registers. The user must write them only while the block is idle;
  // the block itself does not enforce this and takes writes every cycle.
  // --------------------------------------------------------------------------
  logic [uer_pkg::CFG_REG_W-1:0] trigger_period;
  logic [uer_pkg::CFG_REG_W-1:0] echo_timeout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_period <= uer_pkg::TRIGGER_PERIOD_RST;
      echo_timeout   <= uer_pkg::ECHO_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        uer_pkg::REG_TRIGGER_PERIOD: trigger_period <= cfg_data;
        uer_pkg::REG_ECHO_TIMEOUT:   echo_timeout   <= cfg_data;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake. The output stage loads when it is empty or its beat
  // leaves; the first stage loads when it is empty or moves on.
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic out_load;
  logic s1_load;
  logic item_take;

  assign out_load   = !result_valid || !result_stall;
  assign s1_load    = !s1_valid || out_load;
  assign item_stall = !s1_load;
  assign item_take  = item_valid && !item_stall;

  // --------------------------------------------------------------------------
  // Stage 1: ranger state update
  // --------------------------------------------------------------------------
  logic [uer_pkg::CFG_REG_W-1:0] elapsed;
  logic [TIME_WIDTH-1:0]         rising_time;
  logic                          awaiting_falling;
  logic                          ready_flag;
  logic [DW-1:0]                 distance_reg;

  logic [uer_pkg::CFG_REG_W-1:0] elapsed_next;
  logic [TIME_WIDTH-1:0]         rising_time_next;
  logic                          awaiting_falling_next;
  logic                          ready_flag_next;
  logic [DW-1:0]                 distance_reg_next;
  logic                          fire_next;

  logic [uer_pkg::CFG_REG_W-1:0] elapsed_inc;
  logic [TIME_WIDTH-1:0]         stamp;
  logic [TIME_WIDTH-1:0]         pulse_width;
  logic [CW-1:0]                 pulse_wide;
  logic [WQ-1:0]                 pulse_cm;

  assign stamp       = item.capture_time[TIME_WIDTH-1:0];
  assign pulse_width = stamp - rising_time;   // wraps mod 2^TIME_WIDTH
  assign pulse_wide  = CW'(pulse_width);

  uer_cdiv #(
    .IN_W    (WQ),
    .DIVISOR (uer_pkg::US_PER_CM)
  ) u_cm_div (
    .x (pulse_wide[WQ-1:0]),
    .q (pulse_cm)
  );

  always_comb begin
    elapsed_inc           = (elapsed != ELAPSED_MAX) ? elapsed + 1'b1 : elapsed;
    elapsed_next          = elapsed;
    rising_time_next      = rising_time;
    awaiting_falling_next = awaiting_falling;
    ready_flag_next       = ready_flag;
    distance_reg_next     = distance_reg;
    fire_next             = 1'b0;
    case (item.command)
      uer_pkg::CMD_TICK: begin
        // Advance the saturating counter, then test the period on it.
        elapsed_next = elapsed_inc;
        if (elapsed_inc >= trigger_period) begin
          elapsed_next          = '0;
          ready_flag_next       = 1'b0;
          awaiting_falling_next = 1'b0;
          fire_next             = 1'b1;
        end
        // Timeout runs on the possibly cleared counter.
        if (elapsed_next > echo_timeout && !ready_flag_next) begin
          distance_reg_next = MAX_DIST;
        end
      end
      default: begin
        if (!awaiting_falling) begin
          rising_time_next      = stamp;
          awaiting_falling_next = 1'b1;
        end else begin
          // Clamp on the raw width; the divider sees only its low WQ bits.
          if (pulse_wide >= LIMIT_W) begin
            distance_reg_next = MAX_DIST;
          end else if (pulse_cm[DW-1:0] > MAX_DIST) begin
            distance_reg_next = MAX_DIST;
          end else begin
            distance_reg_next = pulse_cm[DW-1:0];
          end
          ready_flag_next       = 1'b1;
          awaiting_falling_next = 1'b0;
        end
      end
    endcase
  end

  // Stage 1 result beat
  logic          s1_fire;
  logic [DW-1:0] s1_distance;
  logic          s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed          <= '0;
      rising_time      <= '0;
      awaiting_falling <= 1'b0;
      ready_flag       <= 1'b0;
      distance_reg     <= '0;
      s1_valid         <= 1'b0;
    end else begin
      if (item_take) begin
        elapsed          <= elapsed_next;
        rising_time      <= rising_time_next;
        awaiting_falling <= awaiting_falling_next;
        ready_flag       <= ready_flag_next;
        distance_reg     <= distance_reg_next;
      end
      if (s1_load) begin
        s1_valid <= item_take;
      end
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_fire     <= fire_next;
      s1_distance <= distance_reg_next;
      s1_ready    <= ready_flag_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: DAC scaling, 4095 - floor(d * 4095 / MAX)
  // d * 4095 is formed as (d << 12) - d.
  // --------------------------------------------------------------------------
  logic [XW-1:0]             dac_prod;
  logic [XW-1:0]             dac_quot;
  logic [uer_pkg::DAC_W-1:0] dac_next;

  assign dac_prod = {s1_distance, {uer_pkg::DAC_W{1'b0}}} - XW'(s1_distance);

  uer_cdiv #(
    .IN_W    (XW),
    .DIVISOR (MAX_DISTANCE_CM)
  ) u_dac_div (
    .x (dac_prod),
    .q (dac_quot)
  );

  assign dac_next = uer_pkg::DAC_FULL - dac_quot[uer_pkg::DAC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      result.trigger_fire  <= s1_fire;
      result.distance      <= uer_pkg::DIST_OUT_W'(s1_distance);
      result.dac_level     <= dac_next;
      result.reading_valid <= s1_ready;
    end
  end

endmodule

FILE: sv/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker: port-level checks for the echo ranger
// Watches the result channel over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module uer_checker #(
  parameter int MAX_DISTANCE_CM = 100
) (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input uer_pkg::result_t result
);

  // Hold a stalled result beat.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result beat changed");

  // Drop all beats across reset.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat right after reset");

  // A trigger clears the ready flag on the same beat.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.trigger_fire) |-> !result.reading_valid)
    else $error("trigger beat shows a valid reading");

  // Zero distance maps to full-scale DAC.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.distance == '0) |-> (result.dac_level == uer_pkg::DAC_FULL))
    else $error("dac level wrong at zero distance");

  // Distance stays within the maximum when it fits the field.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((MAX_DISTANCE_CM > 127) || (result.distance <= MAX_DISTANCE_CM)))
    else $error("distance above maximum");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker #(
  .MAX_DISTANCE_CM (MAX_DISTANCE_CM)
) u_uer_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

FILE: tb/ultrasonic_echo_ranger_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit_tb: self-checking bench for the echo ranger
// Feeds tick and edge-capture beats with random gaps and stalls, predicts
// every reading in-bench and compares it field by field with the DUT.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit_tb;

  localparam int STAMP_BITS    = 32;
  localparam int RANGE_MAX_CM  = 100;
  // Abort when no channel moves a beat for this many cycles; the longest
  // deliberate receiver hold-off is well below it.
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            item_valid   = 1'b0;
  logic                            item_stall;
  uer_pkg::item_t                  item         = '0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  uer_pkg::result_t                result;
  logic                            cfg_valid    = 1'b0;
  logic                            cfg_ready;
  logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [uer_pkg::CFG_REG_W-1:0]   cfg_data     = '0;

  ultrasonic_echo_ranger_unit #(
    .TIME_WIDTH      (STAMP_BITS),
    .MAX_DISTANCE_CM (RANGE_MAX_CM)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Ranger shadow state: the bench's own copy of the counters and registers
  // --------------------------------------------------------------------------
  logic [uer_pkg::CFG_REG_W-1:0]  period_setting;
  logic [uer_pkg::CFG_REG_W-1:0]  timeout_setting;
  logic [15:0]                    elapsed_ms_q;
  logic [uer_pkg::STAMP_W-1:0]    rise_stamp;
  logic                           awaiting_fall;
  logic                           reading_ready;
  logic [uer_pkg::DIST_OUT_W-1:0] shadow_range;

  uer_pkg::item_t   pending_items[$];
  uer_pkg::result_t expected_readings[$];

  int unsigned items_taken      = 0;
  int unsigned readings_checked = 0;
  int unsigned fires_predicted  = 0;
  int unsigned echoes_measured  = 0;
  int unsigned timeouts_forced  = 0;
  int unsigned settings_written = 0;
  int unsigned mismatch_count   = 0;

  logic        idle_enable  = 1'b1;
  logic        hold_request = 1'b0;
  logic        hold_done    = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Apply one beat to the shadow state and return the reading it produces.
  // Tick: count up (saturating), fire when the period is reached, then force
  // the maximum if the timeout has passed with no reading since the trigger.
  // Capture: alternate between latching the rising stamp and measuring.
  function automatic uer_pkg::result_t advance_ranger(input uer_pkg::item_t beat);
    uer_pkg::result_t r;
    logic [31:0]      width;
    logic [31:0]      cm;
    int unsigned      dac;
    r = '0;
    if (beat.command == uer_pkg::CMD_TICK) begin
      if (elapsed_ms_q != 16'hFFFF) begin
        elapsed_ms_q++;
      end
      if (elapsed_ms_q >= period_setting) begin
        elapsed_ms_q   = '0;
        reading_ready  = 1'b0;
        awaiting_fall  = 1'b0;
        r.trigger_fire = 1'b1;
        fires_predicted++;
      end
      if (elapsed_ms_q > timeout_setting && !reading_ready) begin
        if (shadow_range != RANGE_MAX_CM) begin
          timeouts_forced++;
        end
        shadow_range = uer_pkg::DIST_OUT_W'(RANGE_MAX_CM);
      end
    end else if (!awaiting_fall) begin
      rise_stamp    = beat.capture_time;
      awaiting_fall = 1'b1;
    end else begin
      // Width wraps modulo the timer range.
      width = beat.capture_time - rise_stamp;
      cm    = width / uer_pkg::US_PER_CM;
      if (cm > RANGE_MAX_CM) begin
        cm = RANGE_MAX_CM;
      end
      shadow_range  = cm[uer_pkg::DIST_OUT_W-1:0];
      reading_ready = 1'b1;
      awaiting_fall = 1'b0;
      echoes_measured++;
    end
    dac = int'(uer_pkg::DAC_FULL) -
          (int'(shadow_range) * int'(uer_pkg::DAC_FULL)) / RANGE_MAX_CM;
    r.distance      = shadow_range;
    r.dac_level     = dac[uer_pkg::DAC_W-1:0];
    r.reading_valid = reading_ready;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Item side: record accepted beats at the rising edge, drive at the falling
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : take_items
    if (!rst && item_valid && item_stall === 1'b0) begin
      expected_readings.push_back(advance_ranger(item));
      items_taken++;
    end
  end

  // Hold the payload while stalled; drop valid once taken and offer the next
  // pending beat unless this cycle is a random gap.
  always @(negedge clk) begin : drive_items
    int unsigned    acked_count;
    uer_pkg::item_t nxt_item;
    logic           nxt_valid;
    nxt_item  = item;
    nxt_valid = item_valid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (items_taken != acked_count) begin
        acked_count = items_taken;
        nxt_valid   = 1'b0;
      end
      if (!nxt_valid && pending_items.size() != 0 &&
          !(idle_enable && $urandom_range(99) < 12)) begin
        nxt_item  = pending_items.pop_front();
        nxt_valid = 1'b1;
      end
    end
    item       <= nxt_item;
    item_valid <= nxt_valid;
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls plus one long hold-off to back up the block
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_stall
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      result_stall <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      result_stall <= idle_enable && ($urandom_range(99) < 12);
    end
  end

  // Compare each accepted reading with the oldest prediction.
  always @(posedge clk) begin : check_readings
    uer_pkg::result_t want;
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      if (expected_readings.size() == 0) begin
        flag_mismatch($sformatf("unexpected reading %p", result));
      end else begin
        want = expected_readings.pop_front();
        if (result.trigger_fire !== want.trigger_fire)
          flag_mismatch($sformatf("reading %0d trigger_fire %b, want %b",
                                  readings_checked, result.trigger_fire, want.trigger_fire));
        if (result.distance !== want.distance)
          flag_mismatch($sformatf("reading %0d distance %0d, want %0d",
                                  readings_checked, result.distance, want.distance));
        if (result.dac_level !== want.dac_level)
          flag_mismatch($sformatf("reading %0d dac_level %0d, want %0d",
                                  readings_checked, result.dac_level, want.dac_level));
        if (result.reading_valid !== want.reading_valid)
          flag_mismatch($sformatf("reading %0d reading_valid %b, want %b",
                                  readings_checked, result.reading_valid, want.reading_valid));
        readings_checked++;
      end
    end
  end

  // Watchdog: count cycles in which no channel moves a beat.
  always @(posedge clk) begin : watchdog
    if ((item_valid && item_stall === 1'b0) || (result_valid === 1'b1 && !result_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no beat moved for %0d cycles, aborting", STALL_LIMIT);
      $display("ultrasonic_echo_ranger_unit_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Capture time is don't-care on a tick; randomize it anyway.
  task automatic push_tick();
    uer_pkg::item_t beat;
    beat.command      = uer_pkg::CMD_TICK;
    beat.capture_time = $urandom;
    pending_items.push_back(beat);
  endtask

  task automatic push_capture(input logic [uer_pkg::STAMP_W-1:0] stamp);
    uer_pkg::item_t beat;
    beat.command      = uer_pkg::CMD_CAPTURE;
    beat.capture_time = stamp;
    pending_items.push_back(beat);
  endtask

  // Wait until every queued beat is taken and every reading has come back.
  task automatic drain();
    while (pending_items.size() != 0 || item_valid || expected_readings.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write both registers back to back; valid stays high across the pair.
  task automatic program_ranger(input logic [uer_pkg::CFG_REG_W-1:0] period,
                                input logic [uer_pkg::CFG_REG_W-1:0] timeout);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= uer_pkg::REG_TRIGGER_PERIOD;
    cfg_data  <= period;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    period_setting = period;
    @(negedge clk);
    cfg_index <= uer_pkg::REG_ECHO_TIMEOUT;
    cfg_data  <= timeout;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    timeout_setting = timeout;
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  // Mostly tick runs followed by a clean echo pair with random content;
  // the rest is bare tick bursts and stray edges that break the pairing.
  task automatic push_random_traffic(input int unsigned beats, input int unsigned tick_span);
    int unsigned queued;
    int unsigned pick;
    logic [31:0] rise;
    logic [31:0] width;
    queued = 0;
    while (queued < beats) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        repeat ($urandom_range(tick_span)) begin
          push_tick();
          queued++;
        end
        rise = $urandom;
        case ($urandom_range(9))
          0:       width = $urandom;
          1:       width = 58 * $urandom_range(RANGE_MAX_CM + 1) + 57 * $urandom_range(1);
          2:       width = 5790 + $urandom_range(20);
          default: width = $urandom_range(6500);
        endcase
        push_capture(rise);
        push_capture(rise + width);
        queued += 2;
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 2 * tick_span + 1)) begin
          push_tick();
          queued++;
        end
      end else begin
        push_capture($urandom);
        queued++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    period_setting  = uer_pkg::TRIGGER_PERIOD_RST;
    timeout_setting = uer_pkg::ECHO_TIMEOUT_RST;
    elapsed_ms_q    = '0;
    rise_stamp      = '0;
    awaiting_fall   = 1'b0;
    reading_ready   = 1'b0;
    shadow_range    = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset register values: long enough to cross the 35 ms timeout and the
    // 60 ms trigger period several times.
    push_random_traffic(200, 70);
    drain();

    // Directed: short period and timeout so every corner shows quickly.
    program_ranger(16'd4, 16'd1);
    push_tick();                       // elapsed left over from before: may fire
    push_tick();
    push_tick();                       // past timeout, no echo: forced max
    push_capture(32'hFFFF_FFFF);       // rising at the top of the timer
    push_capture(32'h0000_1679);       // wraps: width 5754 -> 99 cm
    push_tick();
    push_tick();                       // fires, clears ready
    push_capture(32'h0000_0000);
    push_capture(32'd5800);            // exactly the maximum
    push_capture(32'hFFFF_FFF0);
    push_capture(32'h0000_0010);       // wrap, tiny width -> 0 cm
    push_capture(32'h7FFF_FFFF);
    push_capture(32'h7FFF_FFFF);       // zero width
    push_capture(32'h0000_0000);
    push_capture(32'hFFFF_FFFF);       // huge width clamps
    push_tick();
    push_capture(32'h1234_5678);       // rising edge
    push_tick();
    push_tick();
    push_capture(32'h1234_5678 + 32'd58);
    push_capture(32'h1234_5678 + 32'd58 * 38);
    drain();

    // Zero period: every tick fires and drops a pending rising edge.
    program_ranger(16'd0, 16'd0);
    push_tick();
    push_tick();
    push_capture(32'h5555_5555);
    push_tick();
    push_capture(32'hAAAA_AAAA);
    drain();

    program_ranger(16'd1, 16'd0);
    push_random_traffic(250, 4);
    drain();

    // Long stretch with no gaps or stalls on either side.
    idle_enable = 1'b0;
    program_ranger(16'd12, 16'd3);
    push_random_traffic(300, 14);
    drain();
    idle_enable = 1'b1;

    // Receiver holds off while the sender keeps offering: input must stall.
    program_ranger(16'd40, 16'd20);
    hold_request = 1'b1;
    push_random_traffic(300, 40);
    drain();

    program_ranger(16'hFFFF, 16'hFFFF);
    push_random_traffic(200, 40);
    drain();

    program_ranger(16'd0, 16'hFFFF);
    push_random_traffic(100, 3);
    drain();

    begin : random_setting
      logic [uer_pkg::CFG_REG_W-1:0] period;
      period = uer_pkg::CFG_REG_W'($urandom_range(5, 90));
      program_ranger(period, uer_pkg::CFG_REG_W'($urandom_range(0, period)));
      push_random_traffic(350, 60);
      drain();
    end

    // Let any stray reading surface before the verdict.
    repeat (20) @(posedge clk);
    if (expected_readings.size() != 0) begin
      flag_mismatch($sformatf("%0d readings never arrived", expected_readings.size()));
    end

    $display("covered %0d beats over %0d register settings, %0d readings compared",
             items_taken, settings_written + 1, readings_checked);
    $display("  triggers fired %0d, echoes measured %0d, timeouts forcing max %0d, errors %0d",
             fires_predicted, echoes_measured, timeouts_forced, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ultrasonic_echo_ranger_unit_tb: PASS");
    end else begin
      $display("ultrasonic_echo_ranger_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
